@@ hw/rtl/tsd_pkg.sv @@
// Shared types, constants and helpers of the touch swipe direction detector.
// No dependencies; every other file of the block depends on this package.
package tsd_pkg;

  // Field widths of the event and result channels
  localparam int unsigned EvTypeBits  = 5;
  localparam int unsigned EvCodeBits  = 10;
  localparam int unsigned EvValueBits = 12;
  localparam int unsigned DirBits     = 3;
  localparam int unsigned CoordBits   = 12;

  localparam logic [EvValueBits-1:0] CoordMax = EvValueBits'((1 << CoordBits) - 1);

  // Event decode codes
  localparam logic [EvTypeBits-1:0] EvtAbs      = 5'd3;
  localparam logic [EvTypeBits-1:0] EvtKey      = 5'd1;
  localparam logic [EvCodeBits-1:0] AxisX       = 10'd0;
  localparam logic [EvCodeBits-1:0] AxisY       = 10'd1;
  localparam logic [EvCodeBits-1:0] ButtonTouch = 10'd330;

  // Command queue between front and back
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrBits  = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits  = QueuePtrBits + 1;

  typedef enum logic [1:0] {
    CMD_SET_X   = 2'd0,
    CMD_SET_Y   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [CoordBits-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_WAIT_X = 2'd0,
    PH_WAIT_Y = 2'd1,
    PH_TRACK  = 2'd2
  } phase_e;

  typedef enum logic [DirBits-1:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  // Saturate a raw event value to the coordinate range
  function automatic logic [CoordBits-1:0] clamp_coord(input logic [EvValueBits-1:0] raw);
    logic [EvValueBits-1:0] sat;
    sat = (raw > CoordMax) ? CoordMax : raw;
    return sat[CoordBits-1:0];
  endfunction

endpackage

@@ hw/rtl/tsd_if.sv @@
// Valid/ready channel interfaces: touch events in, swipe results out.
// Depends on tsd_pkg for the field widths.
interface tsd_ev_if;
  logic                               valid;
  logic                               ready;
  logic [tsd_pkg::EvTypeBits-1:0]     ev_type;
  logic [tsd_pkg::EvCodeBits-1:0]     ev_code;
  logic [tsd_pkg::EvValueBits-1:0]    ev_value;

  modport source (output valid, ev_type, ev_code, ev_value, input ready);
  modport sink   (input valid, ev_type, ev_code, ev_value, output ready);
endinterface

interface tsd_res_if;
  logic                               valid;
  logic                               ready;
  logic [tsd_pkg::DirBits-1:0]        direction;
  logic [tsd_pkg::EvValueBits-1:0]    start_x;
  logic [tsd_pkg::EvValueBits-1:0]    start_y;
  logic [tsd_pkg::EvValueBits-1:0]    end_x;
  logic [tsd_pkg::EvValueBits-1:0]    end_y;

  modport source (output valid, direction, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, direction, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ hw/rtl/tsd_front.sv @@
// Front end: decodes touch events into queue commands and drops the rest.
// Depends on tsd_pkg.
module tsd_front (
  input  logic                              ev_valid_i,
  output logic                              ev_ready_o,
  input  logic [tsd_pkg::EvTypeBits-1:0]    ev_type_i,
  input  logic [tsd_pkg::EvCodeBits-1:0]    ev_code_i,
  input  logic [tsd_pkg::EvValueBits-1:0]   ev_value_i,
  output logic                              push_o,
  output tsd_pkg::cmd_t                     push_cmd_o,
  input  logic                              full_i
);
  import tsd_pkg::*;

  logic is_x;
  logic is_y;
  logic is_release;

  always_comb begin
    is_x       = (ev_type_i == EvtAbs) && (ev_code_i == AxisX);
    is_y       = (ev_type_i == EvtAbs) && (ev_code_i == AxisY);
    is_release = (ev_type_i == EvtKey) && (ev_code_i == ButtonTouch) && (ev_value_i == '0);

    push_cmd_o.value = clamp_coord(ev_value_i);
    if (is_x) begin
      push_cmd_o.op = CMD_SET_X;
    end else if (is_y) begin
      push_cmd_o.op = CMD_SET_Y;
    end else begin
      push_cmd_o.op = CMD_RELEASE;
    end
  end

  // Stall only when the queue is full; irrelevant events transfer and vanish
  assign ev_ready_o = !full_i;
  assign push_o     = ev_valid_i && !full_i && (is_x || is_y || is_release);

endmodule

@@ hw/rtl/tsd_cmd_fifo.sv @@
// Short command queue that decouples the decode front from the state back end.
// Depends on tsd_pkg for the command type and depth.
module tsd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsd_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          head_valid_o,
  output tsd_pkg::cmd_t head_cmd_o,
  input  logic          pop_i
);
  import tsd_pkg::*;

  cmd_t                    mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntBits-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o       = (count_q == QueueCntBits'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("command queue read while empty");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntBits'(QueueDepth))
    else $error("command queue count out of range");
`endif

endmodule

@@ hw/rtl/tsd_back.sv @@
// Back end: runs the three-phase swipe machine and holds the result register.
// Depends on tsd_pkg.
module tsd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  tsd_pkg::cmd_t                     head_cmd_i,
  output logic                              pop_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic [tsd_pkg::DirBits-1:0]       res_direction_o,
  output logic [tsd_pkg::EvValueBits-1:0]   res_start_x_o,
  output logic [tsd_pkg::EvValueBits-1:0]   res_start_y_o,
  output logic [tsd_pkg::EvValueBits-1:0]   res_end_x_o,
  output logic [tsd_pkg::EvValueBits-1:0]   res_end_y_o
);
  import tsd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [CoordBits-1:0] first_x_q, first_x_d;
  logic [CoordBits-1:0] first_y_q, first_y_d;
  logic [CoordBits-1:0] last_x_q, last_x_d;
  logic [CoordBits-1:0] last_y_q, last_y_d;
  logic                 out_valid_q, out_valid_d;
  dir_e                 out_dir_q;
  logic [CoordBits-1:0] out_sx_q, out_sy_q, out_ex_q, out_ey_q;

  logic                 slot_free;
  logic                 emit;
  logic [CoordBits-1:0] dx, dy;
  dir_e                 dir;

  // Displacements and direction from the stored start and end points
  always_comb begin
    dy  = (first_y_q > last_y_q) ? first_y_q - last_y_q : last_y_q - first_y_q;
    dx  = (first_x_q > last_x_q) ? first_x_q - last_x_q : last_x_q - first_x_q;
    dir = DIR_NONE;
    if (dy > dx) begin
      if (first_y_q > last_y_q) begin
        dir = DIR_UP;
      end else if (first_y_q < last_y_q) begin
        dir = DIR_DOWN;
      end
    end else if (dy < dx) begin
      if (first_x_q > last_x_q) begin
        dir = DIR_LEFT;
      end else if (first_x_q < last_x_q) begin
        dir = DIR_RIGHT;
      end
    end
  end

  assign slot_free = !out_valid_q || res_ready_i;

  always_comb begin
    phase_d     = phase_q;
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    emit        = 1'b0;
    // Hold a release in tracking until the result register can take it
    pop_o       = head_valid_i &&
                  (slot_free || !(phase_q == PH_TRACK && head_cmd_i.op == CMD_RELEASE));
    out_valid_d = out_valid_q && !res_ready_i;
    if (pop_o) begin
      case (phase_q)
        PH_WAIT_Y: begin
          if (head_cmd_i.op == CMD_SET_Y) begin
            first_y_d = head_cmd_i.value;
            phase_d   = PH_TRACK;
          end
        end
        PH_TRACK: begin
          case (head_cmd_i.op)
            CMD_SET_X: last_x_d = head_cmd_i.value;
            CMD_SET_Y: last_y_d = head_cmd_i.value;
            default: begin
              emit    = 1'b1;
              phase_d = PH_WAIT_X;
            end
          endcase
        end
        default: begin
          if (head_cmd_i.op == CMD_SET_X) begin
            first_x_d = head_cmd_i.value;
            phase_d   = PH_WAIT_Y;
          end
        end
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_X;
      first_x_q   <= '0;
      first_y_q   <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      first_x_q   <= first_x_d;
      first_y_q   <= first_y_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_dir_q <= dir;
      out_sx_q  <= first_x_q;
      out_sy_q  <= first_y_q;
      out_ex_q  <= last_x_q;
      out_ey_q  <= last_y_q;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign res_direction_o = out_dir_q;
  assign res_start_x_o   = EvValueBits'(out_sx_q);
  assign res_start_y_o   = EvValueBits'(out_sy_q);
  assign res_end_x_o     = EvValueBits'(out_ex_q);
  assign res_end_y_o     = EvValueBits'(out_ey_q);

`ifndef SYNTHESIS
  a_release_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && phase_q == PH_TRACK && head_cmd_i.op == CMD_RELEASE)
      |=> (phase_q == PH_WAIT_X && out_valid_q))
    else $error("release in tracking did not produce a result and rearm");

  a_result_needs_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(phase_q) == PH_TRACK)
    else $error("result raised outside the tracking phase");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ready_i) |-> !emit)
    else $error("pending result overwritten");
`endif

endmodule

@@ hw/rtl/touch_swipe_direction_detector_unit.sv @@
// Touch swipe direction detector: one touch event (type, code, value) transfers per cycle on
// ev_i whenever the two-entry command queue has room; the back end retires one queued command
// per cycle unless a release in tracking waits for the result register, so the sustained rate
// is one event per cycle while results are taken. X, Y and touch-release events are queued,
// all other events transfer and are dropped. A release during tracking passes through the
// command queue and then loads the result register, which drives res_o. A result that waits
// on res_o holds the next release in tracking at the queue head, and events behind it back
// up into the queue and stall ev_i once it is full. No clearing pass follows reset.
// Depends on tsd_pkg, tsd_if, tsd_front, tsd_cmd_fifo and tsd_back.
module touch_swipe_direction_detector_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsd_ev_if.sink    ev_i,
  tsd_res_if.source res_o
);
  import tsd_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  tsd_front u_front (
    .ev_valid_i (ev_i.valid),
    .ev_ready_o (ev_i.ready),
    .ev_type_i  (ev_i.ev_type),
    .ev_code_i  (ev_i.ev_code),
    .ev_value_i (ev_i.ev_value),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  tsd_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  tsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_cmd_i      (head_cmd),
    .pop_o           (pop),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .res_direction_o (res_o.direction),
    .res_start_x_o   (res_o.start_x),
    .res_start_y_o   (res_o.start_y),
    .res_end_x_o     (res_o.end_x),
    .res_end_y_o     (res_o.end_y)
  );

endmodule
